/* hdl/bda_pkg.sv */
// Shared types, constants and the shift-and-add-3 step function for the decimal text block.
`default_nettype none

package bda_pkg;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned CHAR_W       = 7;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned NUM_DIGITS   = 10;
  localparam int unsigned DIGIT_IDX_W  = 4;
  localparam int unsigned NUM_STAGES   = 4;
  localparam int unsigned STAGE_STEPS  = VALUE_W / NUM_STAGES;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_signed;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic [LEN_W-1:0]  length;
  } out_word_t;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // Conversion state carried down the pipeline.
  typedef struct packed {
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
    logic               neg;
  } conv_t;

  // Run STAGE_STEPS iterations: correct each digit, then shift one bit in.
  function automatic conv_t dabble_steps(input conv_t s);
    conv_t r;
    r = s;
    for (int it = 0; it < STAGE_STEPS; it++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r.bcd[d] >= 4'd5) begin
          r.bcd[d] = r.bcd[d] + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/bda_dabble_stage.sv */
// One register stage of the binary to BCD conversion pipeline.
`default_nettype none

module bda_dabble_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bda_pkg::conv_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bda_pkg::conv_t     out_data
);

  logic           valid_r;
  logic           valid_nxt;
  bda_pkg::conv_t data_r;
  bda_pkg::conv_t data_nxt;

  // Hold while a word sits here and the next stage stalls.
  assign in_stall = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
      data_nxt  = bda_pkg::dabble_steps(in_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* hdl/bda_serializer.sv */
// Character serializer: turns a finished BCD word into ASCII characters, one per cycle while the output does not stall.
`default_nettype none

module bda_serializer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bda_pkg::conv_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bda_pkg::out_word_t     out_word
);

  logic                                busy_r, busy_nxt;
  logic                                neg_pend_r, neg_pend_nxt;
  logic [bda_pkg::DIGIT_IDX_W-1:0]     dig_idx_r, dig_idx_nxt;
  logic [bda_pkg::LEN_W-1:0]           total_r, total_nxt;
  bda_pkg::bcd_t                       bcd_r, bcd_nxt;
  logic                                out_valid_r, out_valid_nxt;
  bda_pkg::out_word_t                  out_word_r, out_word_nxt;

  logic                                load;
  logic                                emit;
  logic                                is_final;
  logic [bda_pkg::DIGIT_IDX_W-1:0]     top_idx;

  assign in_stall = busy_r;
  assign load     = in_valid && !busy_r;
  assign emit     = busy_r && (!out_valid_r || !out_stall);
  assign is_final = !neg_pend_r && (dig_idx_r == '0);

  // Highest nonzero digit; zero still prints one digit.
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < bda_pkg::NUM_DIGITS; i++) begin
      if (in_data.bcd[i] != 4'd0) begin
        top_idx = bda_pkg::DIGIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    neg_pend_nxt  = neg_pend_r;
    dig_idx_nxt   = dig_idx_r;
    total_nxt     = total_r;
    bcd_nxt       = bcd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    if (load) begin
      busy_nxt     = 1'b1;
      neg_pend_nxt = in_data.neg;
      dig_idx_nxt  = top_idx;
      bcd_nxt      = in_data.bcd;
      total_nxt    = bda_pkg::LEN_W'(top_idx) + 4'd1 + {3'd0, in_data.neg};
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      if (neg_pend_r) begin
        out_word_nxt.character = bda_pkg::CHAR_MINUS;
        out_word_nxt.last      = 1'b0;
        out_word_nxt.length    = '0;
        neg_pend_nxt           = 1'b0;
      end else begin
        out_word_nxt.character = bda_pkg::CHAR_ZERO + {3'd0, bcd_r[dig_idx_r]};
        out_word_nxt.last      = is_final;
        out_word_nxt.length    = is_final ? total_r : '0;
        if (is_final) begin
          busy_nxt = 1'b0;
        end else begin
          dig_idx_nxt = dig_idx_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_pend_r <= neg_pend_nxt;
    dig_idx_r  <= dig_idx_nxt;
    total_r    <= total_nxt;
    bcd_r      <= bcd_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

/* hdl/binary_to_decimal_ascii.sv */
// Top level: 32-bit word to decimal ASCII text, one character per output word.
//
//   Channel | Ports                             | Word
//   --------+-----------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_word       | value[31:0], is_signed
//   output  | out_valid, out_stall, out_word    | character[6:0], last, length
//
// At the serializer a word needs a load, then one character per cycle while the output
// does not stall (1 to 11 characters); a new word loads only after the current word's last character.
// From input to first character a word passes the sign stage, four conversion stages
// of eight shift steps each, the serializer load and the emit register.
// Reset (rst_n low, synchronous) drops every word in flight.
// Stall on the output holds the current character; the pipeline behind it
// fills and then stalls the input, losing and repeating nothing.
`default_nettype none

module binary_to_decimal_ascii (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bda_pkg::in_word_t   in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bda_pkg::out_word_t       out_word
);

  // Sign stage: form the magnitude of a negative signed value.
  logic            prep_valid_r, prep_valid_nxt;
  bda_pkg::conv_t  prep_data_r, prep_data_nxt;
  logic            prep_stall;
  logic            neg;

  // Handshake between the stages; index 0 is the sign stage output.
  logic                                 stg_valid [bda_pkg::NUM_STAGES+1];
  logic                                 stg_stall [bda_pkg::NUM_STAGES+1];
  bda_pkg::conv_t                       stg_data  [bda_pkg::NUM_STAGES+1];

  assign neg      = in_word.is_signed && in_word.value[bda_pkg::VALUE_W-1];
  assign in_stall = prep_valid_r && prep_stall;

  always_comb begin
    prep_valid_nxt = prep_valid_r;
    prep_data_nxt  = prep_data_r;
    if (!in_stall) begin
      prep_valid_nxt    = in_valid;
      prep_data_nxt.bcd = '0;
      prep_data_nxt.neg = neg;
      // Unsigned negate also gives 2147483648 for the most negative value.
      prep_data_nxt.bin = neg ? (~in_word.value + 1'b1) : in_word.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else begin
      prep_valid_r <= prep_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prep_data_r <= prep_data_nxt;
  end

  assign stg_valid[0] = prep_valid_r;
  assign stg_data[0]  = prep_data_r;
  assign prep_stall   = stg_stall[0];

  // Conversion pipeline: eight shift-and-add-3 steps per stage.
  for (genvar s = 0; s < bda_pkg::NUM_STAGES; s++) begin : g_stage
    bda_dabble_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[s]),
      .in_stall  (stg_stall[s]),
      .in_data   (stg_data[s]),
      .out_valid (stg_valid[s+1]),
      .out_stall (stg_stall[s+1]),
      .out_data  (stg_data[s+1])
    );
  end

  // Walk the digits out, minus sign first.
  bda_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stg_valid[bda_pkg::NUM_STAGES]),
    .in_stall  (stg_stall[bda_pkg::NUM_STAGES]),
    .in_data   (stg_data[bda_pkg::NUM_STAGES]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench for binary_to_decimal_ascii: directed and random words against a text predictor.
`timescale 1ns / 100ps

module tb;

  // Stop the run when this many cycles pass with no word moving on either side.
  // The longest correct quiet stretch is a sender gap plus a receiver stall run
  // plus the pipeline depth.
  localparam int unsigned STUCK_LIMIT  = 2000;
  // Cycles to keep watching after the last expected character, to catch extras.
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_WORDS = 240;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  bda_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bda_pkg::out_word_t out_word;

  // Characters still due from the block, oldest first.
  bda_pkg::out_word_t text_q[$];
  int unsigned mismatches  = 0;
  int unsigned burst_left  = 0;
  int unsigned quiet_count = 0;
  int unsigned stall_tick  = 0;

  binary_to_decimal_ascii u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the decimal text of one accepted word and queue its characters.
  // A signed word with the top bit set gets a minus; its magnitude is formed
  // in unsigned arithmetic so the most negative value converts exactly.
  task automatic queue_decimal_text(input logic [bda_pkg::VALUE_W-1:0] val, input logic sgn);
    logic                        neg;
    logic [bda_pkg::VALUE_W-1:0] mag;
    logic [3:0]                  digit_buf[bda_pkg::NUM_DIGITS];
    int                          n;
    int                          total;
    bda_pkg::out_word_t          w;
    neg = sgn && val[bda_pkg::VALUE_W-1];
    mag = neg ? (32'd0 - val) : val;
    n   = 0;
    // Collect digits least significant first; zero still yields one digit.
    do begin
      digit_buf[n] = 4'(mag % 10);
      mag          = mag / 10;
      n++;
    end while (mag != 0);
    total = n + (neg ? 1 : 0);
    if (neg) begin
      w.character = bda_pkg::CHAR_MINUS;
      w.last      = 1'b0;
      w.length    = '0;
      text_q.push_back(w);
    end
    for (int i = n - 1; i >= 0; i--) begin
      w.character = bda_pkg::CHAR_ZERO + bda_pkg::CHAR_W'(digit_buf[i]);
      w.last      = (i == 0);
      w.length    = (i == 0) ? bda_pkg::LEN_W'(total) : '0;
      text_q.push_back(w);
    end
  endtask

  // Offer one word and hold it until the block takes it. The sender runs in
  // bursts: when a burst is used up, drop valid for a random gap first.
  task automatic send_word(input logic [bda_pkg::VALUE_W-1:0] val, input logic sgn);
    bda_pkg::in_word_t w;
    w.value     = val;
    w.is_signed = sgn;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      // Mostly short bursts, now and then a long one with no idling at all.
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 20)
                                                : $urandom_range(8, 1);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    queue_decimal_text(val, sgn);
  endtask

  // Pick a random word. Mix full-range values, values spread evenly over the
  // digit counts (with negatives), and values around the signed and unsigned
  // limits so the wrap points see plenty of traffic.
  function automatic bda_pkg::in_word_t pick_random_word();
    bda_pkg::in_word_t w;
    int unsigned       kind;
    int unsigned       ndig;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mag;
    logic [31:0]       base;
    kind        = $urandom_range(9, 0);
    w.is_signed = 1'($urandom_range(1, 0));
    if (kind < 4) begin
      w.value = $urandom;
    end else if (kind < 8) begin
      ndig = $urandom_range(bda_pkg::NUM_DIGITS, 1);
      lo   = 1;
      repeat (ndig - 1) lo = lo * 10;
      hi   = (ndig == bda_pkg::NUM_DIGITS) ? 32'hFFFF_FFFF : lo * 10 - 1;
      if (ndig == 1) lo = 0;
      mag  = $urandom_range(hi, lo);
      if (w.is_signed && $urandom_range(1, 0) && mag <= 32'h8000_0000) begin
        w.value = 32'd0 - mag;
      end else begin
        w.value = mag;
      end
    end else begin
      case ($urandom_range(3, 0))
        0: base = 32'h0000_0000;
        1: base = 32'h7FFF_FFFF;
        2: base = 32'h8000_0000;
        default: base = 32'hFFFF_FFFF;
      endcase
      if ($urandom_range(1, 0)) begin
        w.value = base + $urandom_range(20, 0);
      end else begin
        w.value = base - $urandom_range(20, 0);
      end
    end
    return w;
  endfunction

  // Zero, all ones and the sign boundaries, each read both ways; then 0x80000001, 1 and -10 read as signed.
  task automatic test_extremes();
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0001, 1'b1);
    send_word(32'h0000_0001, 1'b1);
    send_word(32'hFFFF_FFF6, 1'b1);
  endtask

  // Step across digit-count boundaries, positive and negative.
  task automatic test_decades();
    send_word(32'd9, 1'b0);
    send_word(32'd10, 1'b1);
    send_word(32'd99, 1'b0);
    send_word(32'd100, 1'b0);
    send_word(32'd999_999_999, 1'b1);
    send_word(32'd1_000_000_000, 1'b0);
    send_word(32'd4_000_000_000, 1'b0);
    send_word(32'd0 - 32'd9, 1'b1);
    send_word(32'd0 - 32'd1_000_000_000, 1'b1);
  endtask

  task automatic test_random_words();
    bda_pkg::in_word_t w;
    repeat (RANDOM_WORDS) begin
      w = pick_random_word();
      send_word(w.value, w.is_signed);
    end
  endtask

  // Receiver: check each accepted character against the oldest one due, and
  // drive stall. The stall pattern walks through four phases in turn:
  // never, light random, heavy random, then a regular pattern.
  always @(posedge clk) begin
    bda_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %0d last %0b len %0d",
                 $time, out_word.character, out_word.last, out_word.length);
        mismatches++;
      end else begin
        want = text_q.pop_front();
        if (out_word.character !== want.character) begin
          $display("%0t: character mismatch: expected %0d, actual %0d",
                   $time, want.character, out_word.character);
          mismatches++;
        end
        if (out_word.last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_word.last);
          mismatches++;
        end
        if (out_word.length !== want.length) begin
          $display("%0t: length mismatch: expected %0d, actual %0d",
                   $time, want.length, out_word.length);
          mismatches++;
        end
      end
    end
    stall_tick++;
    case ((stall_tick / 64) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3, 0) == 0);
      2: out_stall <= ($urandom_range(3, 0) != 0);
      default: out_stall <= (stall_tick % 3 == 0);
    endcase
  end

  // Watchdog: count cycles where no word moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else if (quiet_count + 1 >= STUCK_LIMIT) begin
      $display("binary_to_decimal_ascii verification failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    // Hold reset at the start, then release it once for the whole run.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_decades();
    test_random_words();
    in_valid <= 1'b0;

    // Drain the text still due, then watch a while for stray characters.
    while (text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && text_q.size() == 0) begin
      $display("binary_to_decimal_ascii verification clean");
    end else begin
      $display("binary_to_decimal_ascii verification failed");
    end
    $finish;
  end

endmodule
